// ----- rtl/hctms_pkg.sv -----
// shared types and constants for the heater cycle trimmed mean sampler
// no dependencies; used by hctms_ctrl, hctms_dp and the top level
package hctms_pkg;

    localparam int CFG_W  = 20;
    localparam int MEAN_W = 16;
    localparam int CODE_W = 3;

    localparam logic [CFG_W-1:0] WARMUP_RESET  = CFG_W'(90000);
    localparam logic [CFG_W-1:0] HIGH_RESET    = CFG_W'(60000);
    localparam logic [CFG_W-1:0] LOW_RESET     = CFG_W'(60000);
    localparam logic [CFG_W-1:0] MEASURE_RESET = CFG_W'(30000);

    localparam logic [MEAN_W-1:0] MEAN_SAT = '1;

    typedef enum logic [2:0] {
        REG_HEATER_ENABLE = 3'd0,
        REG_WARMUP_TICKS  = 3'd1,
        REG_HIGH_TICKS    = 3'd2,
        REG_LOW_TICKS     = 3'd3,
        REG_MEASURE_TICKS = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FN_SAMPLE = 2'd0,
        FN_TICK   = 2'd1,
        FN_READ   = 2'd2,
        FN_NOP    = 2'd3
    } func_t;

    typedef enum logic [4:0] {
        PH_OFF  = 5'b00001,
        PH_WARM = 5'b00010,
        PH_HIGH = 5'b00100,
        PH_LOW  = 5'b01000,
        PH_MEAS = 5'b10000
    } phase_t;

    localparam logic [CODE_W-1:0] CODE_OFF  = 3'd0;
    localparam logic [CODE_W-1:0] CODE_WARM = 3'd1;
    localparam logic [CODE_W-1:0] CODE_HIGH = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LOW  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_MEAS = 3'd4;

    typedef struct packed {
        logic capture;
        logic div_load;
        logic div_step;
        logic commit;
    } hctms_cmd_t;

    typedef struct packed {
        logic need_div;
    } hctms_status_t;

    function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
        logic [CODE_W-1:0] code;
        case (ph)
            PH_WARM: code = CODE_WARM;
            PH_HIGH: code = CODE_HIGH;
            PH_LOW:  code = CODE_LOW;
            PH_MEAS: code = CODE_MEAS;
            default: code = CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/hctms_ctrl.sv -----
// controller state machine: sequences capture, division steps and commit
// depends on hctms_pkg for the command and status structs
module hctms_ctrl #(
    parameter int DIV_W = 26
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    output logic                     out_valid,
    input  logic                     out_stall,
    input  hctms_pkg::hctms_status_t status,
    output hctms_pkg::hctms_cmd_t    cmd
);
    import hctms_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.need_div)
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == S_EXEC)
        else $error("captured item did not move to execute");

    a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit without a result transfer pending");

    a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == CNT_LAST) |=> state_reg == S_FIN)
        else $error("divider did not finish after the last step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.commit)
        else $error("result overwritten while stalled");

endmodule

// ----- rtl/hctms_dp.sv -----
// datapath: config registers, sampler, heater cycle timing and serial divider
// depends on hctms_pkg for types, constants and the phase code function
module hctms_dp #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 10,
    parameter int FRAC_BITS  = 4,
    parameter int TIME_BITS  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  hctms_pkg::cfg_reg_t                 cfg_index,
    input  logic [hctms_pkg::CFG_W-1:0]         cfg_data,
    input  hctms_pkg::func_t                    func,
    input  logic [ADC_BITS-1:0]                 sample,
    input  hctms_pkg::hctms_cmd_t               cmd,
    output hctms_pkg::hctms_status_t            status,
    output logic [hctms_pkg::MEAN_W-1:0]        mean_value,
    output logic                                mean_fresh,
    output logic                                heater_drive,
    output logic [hctms_pkg::CODE_W-1:0]        heater_phase,
    output logic [COUNT_BITS-1:0]               samples_held
);
    import hctms_pkg::*;

    localparam int SUM_W = ADC_BITS + COUNT_BITS;
    localparam int DIV_W = SUM_W + FRAC_BITS;
    localparam int QX_W  = (DIV_W > MEAN_W) ? DIV_W : MEAN_W;
    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [ADC_BITS-1:0]   ADC_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;

    // configuration
    logic             en_reg;
    logic [CFG_W-1:0] warmup_reg, high_reg, low_reg, meas_reg;

    // captured item
    func_t               item_func_reg;
    logic [ADC_BITS-1:0] item_sample_reg;

    // sampler and cycle state
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [ADC_BITS-1:0]   min_reg, min_next, max_reg, max_next;
    logic [MEAN_W-1:0]     last_mean_reg, last_mean_next;
    logic [MEAN_W-1:0]     latched_reg, latched_next;
    phase_t                phase_reg, phase_next;
    logic [TIME_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                  seen_reg, seen_next;
    logic                  drive_reg, drive_next;
    logic [MEAN_W-1:0]     mean_out_reg, mean_out_next;
    logic                  fresh_reg, fresh_next;

    // divider
    logic [DIV_W-1:0]      div_num_reg, div_quo_reg;
    logic [COUNT_BITS-1:0] div_rem_reg, div_den_reg;
    logic [COUNT_BITS:0]   trial, trial_diff;
    logic                  trial_ge;

    logic [SUM_W-1:0]      sum_eff;
    logic [COUNT_BITS-1:0] count_eff;
    logic [QX_W-1:0]       quo_ext;
    logic [MEAN_W-1:0]     mean_q, live_mean;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic [CFG_W-1:0]      limit;
    logic                  enable_change, advance, have_samples;

    always_comb
    begin
        have_samples = (count_reg != '0);
        if (count_reg >= COUNT_BITS'(3))
        begin
            sum_eff   = sum_reg - SUM_W'(max_reg) - SUM_W'(min_reg);
            count_eff = count_reg - COUNT_BITS'(2);
        end
        else
        begin
            sum_eff   = sum_reg;
            count_eff = count_reg;
        end

        quo_ext   = QX_W'(div_quo_reg);
        mean_q    = ((quo_ext >> MEAN_W) != '0) ? MEAN_SAT : quo_ext[MEAN_W-1:0];
        live_mean = have_samples ? mean_q : last_mean_reg;

        elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        case (phase_reg)
            PH_WARM: limit = warmup_reg;
            PH_HIGH: limit = high_reg;
            PH_LOW:  limit = low_reg;
            PH_MEAS: limit = meas_reg;
            default: limit = '0;
        endcase
        enable_change = (en_reg != seen_reg);
        advance = !enable_change && (phase_reg != PH_OFF)
                  && (CMP_W'(elapsed_inc) >= CMP_W'(limit));

        status.need_div = have_samples &&
                          ((item_func_reg == FN_READ && !en_reg) ||
                           (item_func_reg == FN_TICK && advance && phase_reg == PH_MEAS));
    end

    // one restoring step
    always_comb
    begin
        trial      = {div_rem_reg, div_num_reg[DIV_W-1]};
        trial_diff = trial - (COUNT_BITS + 1)'(div_den_reg);
        trial_ge   = (trial >= (COUNT_BITS + 1)'(div_den_reg));
    end

    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        last_mean_next = last_mean_reg;
        latched_next   = latched_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        seen_next      = seen_reg;
        drive_next     = drive_reg;
        mean_out_next  = '0;
        fresh_next     = 1'b0;
        case (item_func_reg)
            FN_SAMPLE:
            begin
                if (count_reg != COUNT_MAX)
                begin
                    sum_next   = sum_reg + SUM_W'(item_sample_reg);
                    count_next = count_reg + 1'b1;
                    if (item_sample_reg > max_reg)
                    begin
                        max_next = item_sample_reg;
                    end
                    if (item_sample_reg < min_reg)
                    begin
                        min_next = item_sample_reg;
                    end
                end
            end
            FN_TICK:
            begin
                if (enable_change)
                begin
                    phase_next   = en_reg ? PH_WARM : PH_OFF;
                    drive_next   = en_reg;
                    elapsed_next = '0;
                    seen_next    = en_reg;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                    if (advance)
                    begin
                        elapsed_next = '0;
                        case (phase_reg)
                            PH_WARM:
                            begin
                                phase_next = PH_HIGH;
                            end
                            PH_HIGH:
                            begin
                                phase_next = PH_LOW;
                                drive_next = 1'b0;
                            end
                            PH_LOW:
                            begin
                                phase_next = PH_MEAS;
                                sum_next   = '0;
                                count_next = '0;
                                min_next   = ADC_MAX;
                                max_next   = '0;
                            end
                            default:
                            begin
                                latched_next = live_mean;
                                if (have_samples)
                                begin
                                    last_mean_next = mean_q;
                                end
                                drive_next = 1'b1;
                                phase_next = PH_HIGH;
                            end
                        endcase
                    end
                    else if (phase_reg != PH_WARM && phase_reg != PH_HIGH &&
                             phase_reg != PH_LOW && phase_reg != PH_MEAS)
                    begin
                        phase_next = PH_OFF;
                    end
                end
            end
            FN_READ:
            begin
                if (en_reg)
                begin
                    mean_out_next = latched_reg;
                end
                else
                begin
                    fresh_next    = have_samples;
                    mean_out_next = live_mean;
                    if (have_samples)
                    begin
                        last_mean_next = mean_q;
                    end
                    sum_next   = '0;
                    count_next = '0;
                    min_next   = ADC_MAX;
                    max_next   = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            warmup_reg <= WARMUP_RESET;
            high_reg   <= HIGH_RESET;
            low_reg    <= LOW_RESET;
            meas_reg   <= MEASURE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEATER_ENABLE: en_reg     <= cfg_data[0];
                REG_WARMUP_TICKS:  warmup_reg <= cfg_data;
                REG_HIGH_TICKS:    high_reg   <= cfg_data;
                REG_LOW_TICKS:     low_reg    <= cfg_data;
                REG_MEASURE_TICKS: meas_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // item capture, divider and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_func_reg   <= func;
            item_sample_reg <= sample;
        end
        if (cmd.div_load)
        begin
            div_num_reg <= DIV_W'(sum_eff) << FRAC_BITS;
            div_den_reg <= count_eff;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= div_num_reg << 1;
            div_rem_reg <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], trial_ge};
        end
        if (cmd.commit)
        begin
            mean_out_reg <= mean_out_next;
            fresh_reg    <= fresh_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            count_reg     <= '0;
            min_reg       <= ADC_MAX;
            max_reg       <= '0;
            last_mean_reg <= '0;
            latched_reg   <= '0;
            phase_reg     <= PH_OFF;
            elapsed_reg   <= '0;
            seen_reg      <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else if (cmd.commit)
        begin
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            last_mean_reg <= last_mean_next;
            latched_reg   <= latched_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            seen_reg      <= seen_next;
            drive_reg     <= drive_next;
        end
    end

    assign mean_value   = mean_out_reg;
    assign mean_fresh   = fresh_reg;
    assign heater_drive = drive_reg;
    assign heater_phase = phase_code(phase_reg);
    assign samples_held = count_reg;

endmodule

// ----- rtl/heater_cycle_trimmed_mean_sampler.sv -----
// a sample, tick, no-op or latched read is captured, then passes the execute and finish states before its
// result is registered; a live read, or a tick that closes the measure phase, with samples held also
// runs the one-bit-per-cycle divider over ADC_BITS+COUNT_BITS+FRAC_BITS quotient bits (26 by default)
// one item at a time: the next item is taken only after the last result is committed, which waits out an output stall
// reset: asynchronous, active low; sampler cleared, heater off and disabled, timing
// registers at their power-on values
module heater_cycle_trimmed_mean_sampler #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 10,
    parameter int FRAC_BITS  = 4,
    parameter int TIME_BITS  = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  hctms_pkg::cfg_reg_t                 cfg_index,
    input  logic [hctms_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  hctms_pkg::func_t                    func,
    input  logic [ADC_BITS-1:0]                 sample,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [hctms_pkg::MEAN_W-1:0]        mean_value,
    output logic                                mean_fresh,
    output logic                                heater_drive,
    output logic [hctms_pkg::CODE_W-1:0]        heater_phase,
    output logic [COUNT_BITS-1:0]               samples_held
);
    import hctms_pkg::*;

    localparam int DIV_W = ADC_BITS + COUNT_BITS + FRAC_BITS;

    hctms_cmd_t    cmd;
    hctms_status_t status;

    hctms_ctrl #(
        .DIV_W (DIV_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hctms_dp #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .mean_value   (mean_value),
        .mean_fresh   (mean_fresh),
        .heater_drive (heater_drive),
        .heater_phase (heater_phase),
        .samples_held (samples_held)
    );

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for heater_cycle_trimmed_mean_sampler: random and directed
// samples, ticks and reads with a class that predicts each reading and checks it
// depends on hctms_pkg and the rtl top level only
module tb;
    import hctms_pkg::*;

    localparam int ADC_W = 12;
    localparam int CNT_W = 10;
    localparam int FRAC = 4;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic              fresh;
        logic              drive;
        logic [CODE_W-1:0] phase;
        logic [CNT_W-1:0]  held;
    } reading_t;

    class trimmed_mean_tracker;
        reading_t expected_readings[$];
        int items_seen;
        int reads_seen;
        int ticks_seen;
        int compared;
        int mismatches;
        logic enable;
        logic [CFG_W-1:0] warm_len;
        logic [CFG_W-1:0] high_len;
        logic [CFG_W-1:0] low_len;
        logic [CFG_W-1:0] meas_len;
        logic [21:0] acc_sum;
        logic [CNT_W-1:0] acc_count;
        logic [ADC_W-1:0] lo_sample;
        logic [ADC_W-1:0] hi_sample;
        logic [MEAN_W-1:0] recent_mean;
        logic [MEAN_W-1:0] held_mean;
        logic [CODE_W-1:0] stage;
        logic [CFG_W-1:0] stage_ticks;
        logic enable_armed;
        logic drive;

        function new();
            enable = 1'b0;
            warm_len = WARMUP_RESET;
            high_len = HIGH_RESET;
            low_len = LOW_RESET;
            meas_len = MEASURE_RESET;
            clear_sums();
            recent_mean = '0;
            held_mean = '0;
            stage = CODE_OFF;
            stage_ticks = '0;
            enable_armed = 1'b0;
            drive = 1'b0;
        endfunction

        function void clear_sums();
            acc_sum = '0;
            acc_count = '0;
            lo_sample = '1;
            hi_sample = '0;
        endfunction

        function void store_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_HEATER_ENABLE: enable = data[0];
                REG_WARMUP_TICKS:  warm_len = data;
                REG_HIGH_TICKS:    high_len = data;
                REG_LOW_TICKS:     low_len = data;
                REG_MEASURE_TICKS: meas_len = data;
                default: ;
            endcase
        endfunction

        // min and max are dropped once three samples are held
        function logic [MEAN_W-1:0] trimmed_mean();
            logic [25:0] num;
            logic [25:0] div;
            logic [25:0] quot;
            if (acc_count == 0)
                return recent_mean;
            num = 26'(acc_sum);
            div = 26'(acc_count);
            if (acc_count >= 3)
            begin
                num = num - 26'(hi_sample) - 26'(lo_sample);
                div = div - 26'd2;
            end
            quot = (num << FRAC) / div;
            if (quot > 26'(MEAN_SAT))
                quot = 26'(MEAN_SAT);
            recent_mean = quot[MEAN_W-1:0];
            return recent_mean;
        endfunction

        function void advance_tick();
            logic [CFG_W-1:0] limit;
            if (enable != enable_armed)
            begin
                stage = enable ? CODE_WARM : CODE_OFF;
                drive = enable;
                stage_ticks = '0;
                enable_armed = enable;
                return;
            end
            if (stage_ticks != '1)
                stage_ticks++;
            case (stage)
                CODE_WARM: limit = warm_len;
                CODE_HIGH: limit = high_len;
                CODE_LOW:  limit = low_len;
                CODE_MEAS: limit = meas_len;
                default:
                begin
                    stage = CODE_OFF;
                    return;
                end
            endcase
            if (stage_ticks < limit)
                return;
            stage_ticks = '0;
            case (stage)
                CODE_WARM: stage = CODE_HIGH;
                CODE_HIGH:
                begin
                    stage = CODE_LOW;
                    drive = 1'b0;
                end
                CODE_LOW:
                begin
                    clear_sums();
                    stage = CODE_MEAS;
                end
                default:
                begin
                    held_mean = trimmed_mean();
                    drive = 1'b1;
                    stage = CODE_HIGH;
                end
            endcase
        endfunction

        function void accept_item(func_t f, logic [ADC_W-1:0] s);
            reading_t r;
            r.mean = '0;
            r.fresh = 1'b0;
            items_seen++;
            case (f)
                FN_SAMPLE:
                begin
                    if (acc_count != '1)
                    begin
                        acc_sum += 22'(s);
                        acc_count++;
                        if (s > hi_sample)
                            hi_sample = s;
                        if (s < lo_sample)
                            lo_sample = s;
                    end
                end
                FN_TICK:
                begin
                    ticks_seen++;
                    advance_tick();
                end
                FN_READ:
                begin
                    reads_seen++;
                    if (enable)
                        r.mean = held_mean;
                    else
                    begin
                        r.fresh = (acc_count != 0);
                        r.mean = trimmed_mean();
                        clear_sums();
                    end
                end
                default: ;
            endcase
            r.drive = drive;
            r.phase = stage;
            r.held = acc_count;
            expected_readings.push_back(r);
        endfunction

        function void check_field(string label, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t mismatch on %s: expected %0d, actual %0d",
                         $time, label, want, got);
                mismatches++;
            end
        endfunction

        function void compare_reading(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual mean %0d phase %0d",
                         $time, got.mean, got.phase);
                mismatches++;
                return;
            end
            want = expected_readings.pop_front();
            compared++;
            check_field("mean_value", want.mean, got.mean);
            check_field("mean_fresh", want.fresh, got.fresh);
            check_field("heater_drive", want.drive, got.drive);
            check_field("heater_phase", want.phase, got.phase);
            check_field("samples_held", want.held, got.held);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    cfg_reg_t cfg_index = REG_HEATER_ENABLE;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    func_t func = FN_NOP;
    logic [ADC_W-1:0] sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [MEAN_W-1:0] mean_value;
    logic mean_fresh;
    logic heater_drive;
    logic [CODE_W-1:0] heater_phase;
    logic [CNT_W-1:0] samples_held;

    trimmed_mean_tracker tracker;
    bit calm = 1'b0;
    int settings_applied = 0;
    int cycle_count = 0;

    heater_cycle_trimmed_mean_sampler DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .sample(sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .mean_value(mean_value),
        .mean_fresh(mean_fresh),
        .heater_drive(heater_drive),
        .heater_phase(heater_phase),
        .samples_held(samples_held)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[heater_cycle_trimmed_mean_sampler] ERROR");
            $finish;
        end
    end

    function automatic int draw_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return ADC_W'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic func_t pick_func(bit heating);
        int r;
        r = $urandom_range(0, 99);
        if (heating)
        begin
            if (r < 45)
                return FN_TICK;
            if (r < 80)
                return FN_SAMPLE;
            if (r < 95)
                return FN_READ;
            return FN_NOP;
        end
        if (r < 60)
            return FN_SAMPLE;
        if (r < 72)
            return FN_TICK;
        if (r < 95)
            return FN_READ;
        return FN_NOP;
    endfunction

    // valid stays high after a transfer; the next call either reuses it or drops it
    task automatic send_item(input func_t f, input logic [ADC_W-1:0] s);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= f;
        sample <= s;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.accept_item(f, s);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_we <= 1'b1;
        @(posedge clk);
        tracker.store_reg(idx, data);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] en_word, w, h, l, m,
                             input int count);
        settle();
        write_reg(REG_HEATER_ENABLE, en_word);
        write_reg(REG_WARMUP_TICKS, w);
        write_reg(REG_HIGH_TICKS, h);
        write_reg(REG_LOW_TICKS, l);
        write_reg(REG_MEASURE_TICKS, m);
        cfg_we <= 1'b0;
        settings_applied++;
        calm = ($urandom_range(0, 3) == 0);
        repeat (count) send_item(pick_func(en_word[0]), pick_sample());
    endtask

    // result side: after each transfer, hold out_stall high for a random wait from draw_wait, which may be zero
    initial
    begin : drain
        int hold;
        reading_t got;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.mean = mean_value;
                got.fresh = mean_fresh;
                got.drive = heater_drive;
                got.phase = heater_phase;
                got.held = samples_held;
                tracker.compare_reading(got);
                hold = draw_wait();
                out_stall <= (hold != 0);
            end
            else if (hold != 0)
            begin
                hold--;
                if (hold == 0)
                    out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, empty read, one and two samples, trimming, held mean
        send_item(FN_READ, '0);
        send_item(FN_SAMPLE, '0);
        send_item(FN_READ, '1);
        send_item(FN_SAMPLE, '1);
        send_item(FN_SAMPLE, '1);
        send_item(FN_READ, '0);
        send_item(FN_SAMPLE, '0);
        send_item(FN_SAMPLE, '1);
        send_item(FN_SAMPLE, 12'd100);
        send_item(FN_SAMPLE, 12'd200);
        send_item(FN_READ, '0);
        send_item(FN_READ, '0);
        send_item(FN_NOP, '1);
        send_item(FN_TICK, '1);
        send_item(FN_SAMPLE, 12'd7);
        send_item(FN_SAMPLE, 12'd3);
        send_item(FN_SAMPLE, 12'd5);
        send_item(FN_READ, '0);
        send_item(FN_TICK, '0);
        send_item(FN_NOP, '0);

        run_phase(20'h00000, WARMUP_RESET, HIGH_RESET, LOW_RESET, MEASURE_RESET, 80);
        run_phase(20'hFFFFF, 20'd1, 20'd1, 20'd1, 20'd1, 80);
        run_phase(20'h00001, CFG_W'($urandom_range(2, 6)), CFG_W'($urandom_range(2, 6)),
                  CFG_W'($urandom_range(2, 6)), CFG_W'($urandom_range(2, 6)), 80);
        // an upper bit set but enable bit clear: heater turns off
        run_phase(20'h00002, 20'd0, 20'd0, 20'd3, 20'd0, 60);
        run_phase(20'h00001, 20'd0, 20'd0, 20'd3, 20'd0, 80);
        run_phase(20'h00001, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 60);
        run_phase(20'h00000, CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                  CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)), 80);
        run_phase(20'h00001, CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                  CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)), 120);

        settle();
        repeat (36) @(posedge clk);
        $display("covered %0d transfers (%0d reads, %0d ticks) over %0d register settings",
                 tracker.items_seen, tracker.reads_seen, tracker.ticks_seen,
                 settings_applied + 1);
        $display("%0d readings compared, %0d mismatches", tracker.compared,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("[heater_cycle_trimmed_mean_sampler] OK");
        else
            $display("[heater_cycle_trimmed_mean_sampler] ERROR");
        $finish;
    end
endmodule
